// ===== hdl/cpu8_instruction_execute_unit_macros.svh =====
// Assertion macros for the instruction execute unit.
`ifndef CPU8_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define CPU8_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define CIEU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked during and after reset.
`define CIEU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CIEU_ASSERT(label, clk, rst, prop, msg)
`define CIEU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/cpu8ex_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8ex_pkg
// Types, operation codes and constants shared by the execute unit.
// ----------------------------------------------------------------------------
package cpu8ex_pkg;

   localparam logic [5:0] OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3;
   localparam logic [5:0] OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7;
   localparam logic [5:0] OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11;
   localparam logic [5:0] OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15;
   localparam logic [5:0] OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19;
   localparam logic [5:0] OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23;
   localparam logic [5:0] OP_INX = 6'd24, OP_INY = 6'd25, OP_JMP = 6'd26, OP_JSR = 6'd27;
   localparam logic [5:0] OP_LDA = 6'd28, OP_LDX = 6'd29, OP_LDY = 6'd30, OP_LSR = 6'd31;
   localparam logic [5:0] OP_NOP = 6'd32, OP_ORA = 6'd33, OP_PHA = 6'd34, OP_PHP = 6'd35;
   localparam logic [5:0] OP_PLA = 6'd36, OP_PLP = 6'd37, OP_ROL = 6'd38, OP_ROR = 6'd39;
   localparam logic [5:0] OP_RTI = 6'd40, OP_RTS = 6'd41, OP_SBC = 6'd42, OP_SEC = 6'd43;
   localparam logic [5:0] OP_SED = 6'd44, OP_SEI = 6'd45, OP_STA = 6'd46, OP_STX = 6'd47;
   localparam logic [5:0] OP_STY = 6'd48, OP_TAX = 6'd49, OP_TAY = 6'd50, OP_TSX = 6'd51;
   localparam logic [5:0] OP_TXA = 6'd52, OP_TXS = 6'd53, OP_TYA = 6'd54;

   // Flag bit positions.
   localparam int FL_C = 0, FL_Z = 1, FL_I = 2, FL_D = 3;
   localparam int FL_B = 4, FL_U = 5, FL_V = 6, FL_N = 7;

   localparam logic [7:0] SP_RESET    = 8'hFD;
   localparam logic [7:0] FLAGS_RESET = 8'h24;
   localparam logic [7:0] STACK_PAGE  = 8'h01;

   typedef struct packed {
      logic [5:0]        req_type;
      logic [7:0]        operand_byte;
      logic [15:0]       effective_address;
      logic signed [7:0] branch_offset;
      logic [15:0]       pc_after_fetch;
      logic              accumulator_mode;
      logic [7:0]        pull_first;
      logic [7:0]        pull_second;
      logic [7:0]        pull_third;
   } req_type_type;

   typedef struct packed {
      logic        mem_write;
      logic [15:0] write_address;
      logic [7:0]  write_value;
      logic [15:0] next_pc;
      logic [1:0]  extra_cycles;
      logic [7:0]  status_flags;
      logic [7:0]  acc_value;
      logic [7:0]  x_value;
      logic [7:0]  y_value;
      logic [7:0]  stack_pointer;
      logic        last_result;
   } rsp_type_type;

   // Architectural register file.
   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
   } regs_type;

   // Everything one instruction produces; JSR also carries its second push.
   typedef struct packed {
      regs_type    regs;
      logic        mem_write;
      logic [15:0] write_address;
      logic [7:0]  write_value;
      logic [15:0] next_pc;
      logic [1:0]  extra_cycles;
      logic        two_results;
      logic [15:0] second_address;
      logic [7:0]  second_value;
   } exec_type;

endpackage

// ===== hdl/cpu8ex_alu.sv =====
// ----------------------------------------------------------------------------
// cpu8ex_alu
// Single-pass combinational execution of one instruction on the registers.
// ----------------------------------------------------------------------------
module cpu8ex_alu (
   input  cpu8ex_pkg::req_type_type req,
   input  cpu8ex_pkg::regs_type      regs,
   output cpu8ex_pkg::exec_type      result
);
   import cpu8ex_pkg::*;

   logic [7:0]  src;
   logic [7:0]  shift_val;
   logic [7:0]  add_m;
   logic [8:0]  sum;
   logic [7:0]  cmp_reg;
   logic [8:0]  cmp_diff;
   logic [7:0]  nz_val;
   logic        set_nz_flags;
   logic        take;
   logic [15:0] target;
   logic [15:0] ret_addr;
   logic [7:0]  pulled_p;

   always_comb begin
      src      = req.accumulator_mode ? regs.a : req.operand_byte;
      add_m    = (req.req_type == OP_SBC) ? ~req.operand_byte : req.operand_byte;
      sum      = {1'b0, regs.a} + {1'b0, add_m} + {8'd0, regs.p[FL_C]};
      cmp_reg  = (req.req_type == OP_CPX) ? regs.x :
                 (req.req_type == OP_CPY) ? regs.y : regs.a;
      cmp_diff = {1'b0, cmp_reg} - {1'b0, req.operand_byte};
      target   = req.pc_after_fetch + {{8{req.branch_offset[7]}}, req.branch_offset};
      ret_addr = req.pc_after_fetch - 16'd1;
      pulled_p = req.pull_first;
      pulled_p[FL_B] = 1'b0;
      pulled_p[FL_U] = 1'b1;
      case (req.req_type)
         OP_ASL:  shift_val = {src[6:0], 1'b0};
         OP_LSR:  shift_val = {1'b0, src[7:1]};
         OP_ROL:  shift_val = {src[6:0], regs.p[FL_C]};
         default: shift_val = {regs.p[FL_C], src[7:1]};
      endcase
   end

   // Main operation decode.
   always_comb begin
      result                = '0;
      result.regs           = regs;
      result.next_pc        = req.pc_after_fetch;
      nz_val                = 8'd0;
      set_nz_flags          = 1'b0;
      take                  = 1'b0;
      case (req.req_type)
         OP_ADC, OP_SBC: begin
            result.regs.a       = sum[7:0];
            result.regs.p[FL_C] = sum[8];
            result.regs.p[FL_V] = ~(regs.a[7] ^ add_m[7]) & (regs.a[7] ^ sum[7]);
            nz_val = sum[7:0]; set_nz_flags = 1'b1;
         end
         OP_AND: begin
            result.regs.a = regs.a & req.operand_byte;
            nz_val = result.regs.a; set_nz_flags = 1'b1;
         end
         OP_ORA: begin
            result.regs.a = regs.a | req.operand_byte;
            nz_val = result.regs.a; set_nz_flags = 1'b1;
         end
         OP_EOR: begin
            result.regs.a = regs.a ^ req.operand_byte;
            nz_val = result.regs.a; set_nz_flags = 1'b1;
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            result.regs.p[FL_C] = (req.req_type == OP_ASL || req.req_type == OP_ROL) ?
                                  src[7] : src[0];
            nz_val = shift_val; set_nz_flags = 1'b1;
            if (req.accumulator_mode) begin
               result.regs.a = shift_val;
            end else begin
               result.mem_write     = 1'b1;
               result.write_address = req.effective_address;
               result.write_value   = shift_val;
            end
         end
         OP_BCC: take = ~regs.p[FL_C];
         OP_BCS: take = regs.p[FL_C];
         OP_BEQ: take = regs.p[FL_Z];
         OP_BNE: take = ~regs.p[FL_Z];
         OP_BMI: take = regs.p[FL_N];
         OP_BPL: take = ~regs.p[FL_N];
         OP_BVC: take = ~regs.p[FL_V];
         OP_BVS: take = regs.p[FL_V];
         OP_BIT: begin
            result.regs.p[FL_Z] = (regs.a & req.operand_byte) == 8'd0;
            result.regs.p[FL_N] = req.operand_byte[7];
            result.regs.p[FL_V] = req.operand_byte[6];
         end
         OP_CLC: result.regs.p[FL_C] = 1'b0;
         OP_CLD: result.regs.p[FL_D] = 1'b0;
         OP_CLI: result.regs.p[FL_I] = 1'b0;
         OP_CLV: result.regs.p[FL_V] = 1'b0;
         OP_SEC: result.regs.p[FL_C] = 1'b1;
         OP_SED: result.regs.p[FL_D] = 1'b1;
         OP_SEI: result.regs.p[FL_I] = 1'b1;
         OP_CMP, OP_CPX, OP_CPY: begin
            result.regs.p[FL_C] = ~cmp_diff[8];
            nz_val = cmp_diff[7:0]; set_nz_flags = 1'b1;
         end
         OP_DEC, OP_INC: begin
            nz_val = (req.req_type == OP_DEC) ? req.operand_byte - 8'd1 :
                                                req.operand_byte + 8'd1;
            set_nz_flags         = 1'b1;
            result.mem_write     = 1'b1;
            result.write_address = req.effective_address;
            result.write_value   = nz_val;
         end
         OP_DEX: begin
            result.regs.x = regs.x - 8'd1; nz_val = result.regs.x; set_nz_flags = 1'b1;
         end
         OP_DEY: begin
            result.regs.y = regs.y - 8'd1; nz_val = result.regs.y; set_nz_flags = 1'b1;
         end
         OP_INX: begin
            result.regs.x = regs.x + 8'd1; nz_val = result.regs.x; set_nz_flags = 1'b1;
         end
         OP_INY: begin
            result.regs.y = regs.y + 8'd1; nz_val = result.regs.y; set_nz_flags = 1'b1;
         end
         OP_JMP: result.next_pc = req.effective_address;
         OP_JSR: begin
            result.next_pc        = req.effective_address;
            result.regs.sp        = regs.sp - 8'd2;
            result.mem_write      = 1'b1;
            result.write_address  = {STACK_PAGE, regs.sp};
            result.write_value    = ret_addr[15:8];
            result.two_results    = 1'b1;
            result.second_address = {STACK_PAGE, regs.sp - 8'd1};
            result.second_value   = ret_addr[7:0];
         end
         OP_LDA: begin
            result.regs.a = req.operand_byte; nz_val = req.operand_byte; set_nz_flags = 1'b1;
         end
         OP_LDX: begin
            result.regs.x = req.operand_byte; nz_val = req.operand_byte; set_nz_flags = 1'b1;
         end
         OP_LDY: begin
            result.regs.y = req.operand_byte; nz_val = req.operand_byte; set_nz_flags = 1'b1;
         end
         OP_PHA, OP_PHP: begin
            result.regs.sp       = regs.sp - 8'd1;
            result.mem_write     = 1'b1;
            result.write_address = {STACK_PAGE, regs.sp};
            result.write_value   = (req.req_type == OP_PHA) ? regs.a : (regs.p | 8'h30);
         end
         OP_PLA: begin
            result.regs.sp = regs.sp + 8'd1;
            result.regs.a  = req.pull_first;
            nz_val = req.pull_first; set_nz_flags = 1'b1;
         end
         OP_PLP: begin
            result.regs.sp = regs.sp + 8'd1;
            result.regs.p  = pulled_p;
         end
         OP_RTI: begin
            result.regs.sp = regs.sp + 8'd3;
            result.regs.p  = pulled_p;
            result.next_pc = {req.pull_third, req.pull_second};
         end
         OP_RTS: begin
            result.regs.sp = regs.sp + 8'd2;
            result.next_pc = {req.pull_second, req.pull_first} + 16'd1;
         end
         OP_STA, OP_STX, OP_STY: begin
            result.mem_write     = 1'b1;
            result.write_address = req.effective_address;
            result.write_value   = (req.req_type == OP_STA) ? regs.a :
                                   (req.req_type == OP_STX) ? regs.x : regs.y;
         end
         OP_TAX: begin
            result.regs.x = regs.a; nz_val = regs.a; set_nz_flags = 1'b1;
         end
         OP_TAY: begin
            result.regs.y = regs.a; nz_val = regs.a; set_nz_flags = 1'b1;
         end
         OP_TSX: begin
            result.regs.x = regs.sp; nz_val = regs.sp; set_nz_flags = 1'b1;
         end
         OP_TXA: begin
            result.regs.a = regs.x; nz_val = regs.x; set_nz_flags = 1'b1;
         end
         OP_TYA: begin
            result.regs.a = regs.y; nz_val = regs.y; set_nz_flags = 1'b1;
         end
         OP_TXS: result.regs.sp = regs.x;
         default: ;
      endcase
      if (set_nz_flags) begin
         result.regs.p[FL_Z] = (nz_val == 8'd0);
         result.regs.p[FL_N] = nz_val[7];
      end
      // A taken branch redirects the PC and reports extra cycles, more across a page.
      if (take) begin
         result.next_pc      = target;
         result.extra_cycles = (target[15:8] != req.pc_after_fetch[15:8]) ? 2'd2 : 2'd1;
      end
   end

endmodule

// ===== hdl/cpu8_instruction_execute_unit.sv =====
// One instruction is accepted per cycle while the output is free and no second
// push is owed, and its result appears in the result register in the next cycle;
// JSR yields two transfers, so it stalls the input until its second push is sent.
// The rate is set by the single-pass execute logic, which reads the register file
// updated in the previous cycle.
// ----------------------------------------------------------------------------
// cpu8_instruction_execute_unit
// Execute stage of an 8-bit CPU: keeps A, X, Y, SP and flags.
// ----------------------------------------------------------------------------
`include "cpu8_instruction_execute_unit_macros.svh"
module cpu8_instruction_execute_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cpu8ex_pkg::req_type_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cpu8ex_pkg::rsp_type_type  rsp_data
);
   import cpu8ex_pkg::*;

   regs_type     regs_ff, regs_in;
   exec_type     exec;
   rsp_type_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         pend_ff, pend_in;
   logic [15:0]  pend_addr_ff, pend_addr_in;
   logic [7:0]   pend_val_ff, pend_val_in;
   logic         out_free;
   logic         req_xfer;

   cpu8ex_alu u_alu (
      .req    (req_data),
      .regs   (regs_ff),
      .result (exec)
   );

   // The output register can load when empty or being taken this cycle.
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~out_free | pend_ff;
   assign req_xfer  = req_valid & ~req_stall;

   always_comb begin
      regs_in      = regs_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pend_val_in  = pend_val_ff;
      if (pend_ff && out_free) begin
         // Second push of a JSR.
         rsp_in.write_address = pend_addr_ff;
         rsp_in.write_value   = pend_val_ff;
         rsp_in.last_result   = 1'b1;
         rsp_valid_in         = 1'b1;
         pend_in              = 1'b0;
      end else if (req_xfer) begin
         regs_in              = exec.regs;
         rsp_in.mem_write     = exec.mem_write;
         rsp_in.write_address = exec.write_address;
         rsp_in.write_value   = exec.write_value;
         rsp_in.next_pc       = exec.next_pc;
         rsp_in.extra_cycles  = exec.extra_cycles;
         rsp_in.status_flags  = exec.regs.p;
         rsp_in.acc_value     = exec.regs.a;
         rsp_in.x_value       = exec.regs.x;
         rsp_in.y_value       = exec.regs.y;
         rsp_in.stack_pointer = exec.regs.sp;
         rsp_in.last_result   = ~exec.two_results;
         rsp_valid_in         = 1'b1;
         pend_in              = exec.two_results;
         pend_addr_in         = exec.second_address;
         pend_val_in          = exec.second_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff      <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: FLAGS_RESET};
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         regs_ff      <= regs_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      rsp_ff       <= rsp_in;
      pend_addr_ff <= pend_addr_in;
      pend_val_ff  <= pend_val_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A pending second push always follows a first push that is still shown.
   `CIEU_ASSERT(a_pend_has_rsp, clock, reset, pend_ff |-> rsp_valid_ff && !rsp_ff.last_result, "pending push without first result")
   // The unused flag bit stays set.
   `CIEU_ASSERT(a_u_flag, clock, reset, regs_ff.p[FL_U], "unused flag cleared")
   // No input is taken while the second push is still owed.
   `CIEU_ASSERT(a_no_take_pend, clock, reset, pend_ff |-> req_stall, "input taken during push")

endmodule

// ===== verif/cpu8ex_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu8ex_checker
// Watches both channels of the execute unit. It predicts each result from its
// own copy of the register file and compares every transfer field by field.
// ----------------------------------------------------------------------------
module cpu8ex_checker
   import cpu8ex_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_type_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_type_type rsp_data,
   output int           fail_count,
   output int           pending_count,
   output int           result_count
);

   logic [7:0] arch_a, arch_x, arch_y, arch_sp, arch_p;
   rsp_type_type expected_results[$];

   function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
      p[FL_Z] = (v == 8'h00);
      p[FL_N] = v[7];
      return p;
   endfunction

   // Binary add with carry; returns {carry, overflow, sum}.
   function automatic logic [9:0] add_carry(logic [7:0] a, logic [7:0] m, logic c);
      logic [8:0] sum;
      logic       ovf;
      sum = {1'b0, a} + {1'b0, m} + {8'h00, c};
      ovf = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
      return {sum[8], ovf, sum[7:0]};
   endfunction

   function automatic rsp_type_type make_result(logic wr, logic [15:0] adr,
         logic [7:0] val, logic [15:0] pc, logic [1:0] extra, logic last);
      rsp_type_type r;
      r.mem_write     = wr;
      r.write_address = wr ? adr : 16'h0000;
      r.write_value   = wr ? val : 8'h00;
      r.next_pc       = pc;
      r.extra_cycles  = extra;
      r.status_flags  = arch_p;
      r.acc_value     = arch_a;
      r.x_value       = arch_x;
      r.y_value       = arch_y;
      r.stack_pointer = arch_sp;
      r.last_result   = last;
      return r;
   endfunction

   // Execute one instruction on the shadow registers and queue its results.
   task automatic execute_instruction(req_type_type q);
      logic [7:0]  src, res;
      logic [9:0]  sum;
      logic        wr, is_branch, taken;
      logic [15:0] wadr, npc, tgt, ret;
      logic [7:0]  wval;
      logic [1:0]  extra;
      src = q.accumulator_mode ? arch_a : q.operand_byte;
      wr = 1'b0; wadr = 16'h0000; wval = 8'h00; npc = q.pc_after_fetch;
      extra = 2'd0; is_branch = 1'b0; taken = 1'b0;
      case (q.req_type)
         OP_ADC, OP_SBC: begin
            sum = add_carry(arch_a, (q.req_type == OP_SBC) ? ~q.operand_byte
                            : q.operand_byte, arch_p[FL_C]);
            arch_p[FL_C] = sum[9];
            arch_p[FL_V] = sum[8];
            arch_a = sum[7:0];
            arch_p = with_nz(arch_p, arch_a);
         end
         OP_AND: begin arch_a &= q.operand_byte; arch_p = with_nz(arch_p, arch_a); end
         OP_ORA: begin arch_a |= q.operand_byte; arch_p = with_nz(arch_p, arch_a); end
         OP_EOR: begin arch_a ^= q.operand_byte; arch_p = with_nz(arch_p, arch_a); end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            case (q.req_type)
               OP_ASL:  res = {src[6:0], 1'b0};
               OP_LSR:  res = {1'b0, src[7:1]};
               OP_ROL:  res = {src[6:0], arch_p[FL_C]};
               default: res = {arch_p[FL_C], src[7:1]};
            endcase
            arch_p[FL_C] = (q.req_type == OP_ASL || q.req_type == OP_ROL) ? src[7] : src[0];
            arch_p = with_nz(arch_p, res);
            if (q.accumulator_mode) begin
               arch_a = res;
            end else begin
               wr = 1'b1; wadr = q.effective_address; wval = res;
            end
         end
         OP_BCC: begin is_branch = 1'b1; taken = !arch_p[FL_C]; end
         OP_BCS: begin is_branch = 1'b1; taken = arch_p[FL_C]; end
         OP_BEQ: begin is_branch = 1'b1; taken = arch_p[FL_Z]; end
         OP_BNE: begin is_branch = 1'b1; taken = !arch_p[FL_Z]; end
         OP_BMI: begin is_branch = 1'b1; taken = arch_p[FL_N]; end
         OP_BPL: begin is_branch = 1'b1; taken = !arch_p[FL_N]; end
         OP_BVS: begin is_branch = 1'b1; taken = arch_p[FL_V]; end
         OP_BVC: begin is_branch = 1'b1; taken = !arch_p[FL_V]; end
         OP_BIT: begin
            arch_p[FL_Z] = ((arch_a & q.operand_byte) == 8'h00);
            arch_p[FL_N] = q.operand_byte[7];
            arch_p[FL_V] = q.operand_byte[6];
         end
         OP_CLC: arch_p[FL_C] = 1'b0;
         OP_CLD: arch_p[FL_D] = 1'b0;
         OP_CLI: arch_p[FL_I] = 1'b0;
         OP_CLV: arch_p[FL_V] = 1'b0;
         OP_SEC: arch_p[FL_C] = 1'b1;
         OP_SED: arch_p[FL_D] = 1'b1;
         OP_SEI: arch_p[FL_I] = 1'b1;
         OP_CMP, OP_CPX, OP_CPY: begin
            res = (q.req_type == OP_CMP) ? arch_a : (q.req_type == OP_CPX) ? arch_x : arch_y;
            arch_p[FL_C] = (res >= q.operand_byte);
            arch_p = with_nz(arch_p, res - q.operand_byte);
         end
         OP_DEC, OP_INC: begin
            res = (q.req_type == OP_DEC) ? q.operand_byte - 8'd1 : q.operand_byte + 8'd1;
            arch_p = with_nz(arch_p, res);
            wr = 1'b1; wadr = q.effective_address; wval = res;
         end
         OP_DEX: begin arch_x -= 8'd1; arch_p = with_nz(arch_p, arch_x); end
         OP_DEY: begin arch_y -= 8'd1; arch_p = with_nz(arch_p, arch_y); end
         OP_INX: begin arch_x += 8'd1; arch_p = with_nz(arch_p, arch_x); end
         OP_INY: begin arch_y += 8'd1; arch_p = with_nz(arch_p, arch_y); end
         OP_JMP: npc = q.effective_address;
         OP_JSR: begin
            // Two pushes, both reporting the final register values.
            ret = q.pc_after_fetch - 16'd1;
            wadr = {STACK_PAGE, arch_sp};
            tgt = {STACK_PAGE, arch_sp - 8'd1};
            arch_sp -= 8'd2;
            expected_results.push_back(make_result(1'b1, wadr, ret[15:8],
                                       q.effective_address, 2'd0, 1'b0));
            expected_results.push_back(make_result(1'b1, tgt, ret[7:0],
                                       q.effective_address, 2'd0, 1'b1));
            return;
         end
         OP_LDA: begin arch_a = q.operand_byte; arch_p = with_nz(arch_p, arch_a); end
         OP_LDX: begin arch_x = q.operand_byte; arch_p = with_nz(arch_p, arch_x); end
         OP_LDY: begin arch_y = q.operand_byte; arch_p = with_nz(arch_p, arch_y); end
         OP_PHA, OP_PHP: begin
            wr = 1'b1; wadr = {STACK_PAGE, arch_sp};
            wval = (q.req_type == OP_PHA) ? arch_a : (arch_p | 8'h30);
            arch_sp -= 8'd1;
         end
         OP_PLA: begin
            arch_sp += 8'd1; arch_a = q.pull_first; arch_p = with_nz(arch_p, arch_a);
         end
         OP_PLP: begin arch_sp += 8'd1; arch_p = (q.pull_first & 8'hEF) | 8'h20; end
         OP_RTI: begin
            arch_sp += 8'd3;
            arch_p = (q.pull_first & 8'hEF) | 8'h20;
            npc = {q.pull_third, q.pull_second};
         end
         OP_RTS: begin
            arch_sp += 8'd2;
            npc = {q.pull_second, q.pull_first} + 16'd1;
         end
         OP_STA: begin wr = 1'b1; wadr = q.effective_address; wval = arch_a; end
         OP_STX: begin wr = 1'b1; wadr = q.effective_address; wval = arch_x; end
         OP_STY: begin wr = 1'b1; wadr = q.effective_address; wval = arch_y; end
         OP_TAX: begin arch_x = arch_a; arch_p = with_nz(arch_p, arch_x); end
         OP_TAY: begin arch_y = arch_a; arch_p = with_nz(arch_p, arch_y); end
         OP_TSX: begin arch_x = arch_sp; arch_p = with_nz(arch_p, arch_x); end
         OP_TXA: begin arch_a = arch_x; arch_p = with_nz(arch_p, arch_a); end
         OP_TYA: begin arch_a = arch_y; arch_p = with_nz(arch_p, arch_a); end
         OP_TXS: arch_sp = arch_x;
         default: ;
      endcase
      if (is_branch && taken) begin
         tgt = q.pc_after_fetch + {{8{q.branch_offset[7]}}, q.branch_offset};
         extra = (tgt[15:8] != q.pc_after_fetch[15:8]) ? 2'd2 : 2'd1;
         npc = tgt;
      end
      expected_results.push_back(make_result(wr, wadr, wval, npc, extra, 1'b1));
   endtask

   assign pending_count = expected_results.size();

   // Sample both channels at the clock edge; inputs change only after it.
   always @(posedge clock) begin
      rsp_type_type want;
      if (reset) begin
         arch_sp = SP_RESET;
         arch_p = FLAGS_RESET;
         arch_a = 8'h00; arch_x = 8'h00; arch_y = 8'h00;
         expected_results.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result transfer, actual %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: result mismatch, expected %h, actual %h",
                           $time, want, rsp_data);
                  $display("   flags exp %h act %h, pc exp %h act %h, a/x/y/sp exp %h act %h",
                           want.status_flags, rsp_data.status_flags, want.next_pc,
                           rsp_data.next_pc,
                           {want.acc_value, want.x_value, want.y_value, want.stack_pointer},
                           {rsp_data.acc_value, rsp_data.x_value, rsp_data.y_value,
                            rsp_data.stack_pointer});
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            execute_instruction(req_data);
      end
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random instructions into the execute unit, the random ones
// under varying idle and stall patterns; the checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
   import cpu8ex_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_type_type rsp_data;
   int           fail_count, pending_count, result_count;
   int           send_idle_pct = 0, stall_pct = 0, sent_count = 0;

   always #1 clock = ~clock;

   cpu8_instruction_execute_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   cpu8ex_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   // Receiver stall, redrawn every cycle.
   always @(posedge clock)
      rsp_stall <= (int'($urandom_range(99)) < stall_pct);

   // Random instruction; mostly defined operations, a few unused codes.
   function automatic req_type_type random_instruction();
      req_type_type q;
      logic [95:0]  raw;
      raw = {$urandom, $urandom, $urandom};
      q = raw[$bits(req_type_type)-1:0];
      if ($urandom_range(19) != 0)
         q.req_type = 6'($urandom_range(54));
      return q;
   endfunction

   // One transfer on the input channel, with optional idle cycles before it.
   task automatic send_instruction(req_type_type q);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_directed(logic [5:0] op, logic [7:0] m, logic [15:0] ea,
                                logic [7:0] off, logic [15:0] pc, logic accm,
                                logic [7:0] p1, logic [7:0] p2, logic [7:0] p3);
      req_type_type q;
      q = '{op, m, ea, off, pc, accm, p1, p2, p3};
      send_instruction(q);
   endtask

   initial begin
      int wait_cycles;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, carry and overflow, stack wrap, calls and returns.
      send_directed(OP_LDA, 8'hFF, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_ADC, 8'h01, 16'hFFFF, 8'h7F, 16'hFFFF, 1'b0, 8'hFF, 8'hFF, 8'hFF);
      send_directed(OP_LDA, 8'h7F, 16'h0000, 8'h00, 16'h1234, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_ADC, 8'h01, 16'h0000, 8'h00, 16'h1234, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_SBC, 8'hFF, 16'h0000, 8'h00, 16'h1234, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_BVS, 8'h00, 16'h0000, 8'h80, 16'h1200, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_BVC, 8'h00, 16'h0000, 8'h7F, 16'h12F0, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_ROL, 8'h00, 16'h0000, 8'h00, 16'h0010, 1'b1, 8'h00, 8'h00, 8'h00);
      send_directed(OP_ROR, 8'h81, 16'hABCD, 8'h00, 16'h0010, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_LSR, 8'h01, 16'h0000, 8'h00, 16'h0010, 1'b1, 8'h00, 8'h00, 8'h00);
      send_directed(OP_JSR, 8'h00, 16'hC000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_RTS, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'hFF, 8'hFF, 8'h00);
      send_directed(OP_PHP, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_PLP, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'hFF, 8'h00, 8'h00);
      send_directed(OP_RTI, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h10, 8'h34, 8'h12);
      send_directed(OP_LDX, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_TXS, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_PHA, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_PLA, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h80, 8'h00, 8'h00);
      send_directed(OP_SED, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_ADC, 8'h09, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(6'd63,  8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_directed(OP_CMP, 8'h80, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);
      send_directed(OP_TSX, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 8'h00);

      // Random phases with different idle patterns on each side.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 58 : 0;
         stall_pct     = (phase == 0) ? 58 : (phase == 1) ? 6 : 0;
         repeat (560) send_instruction(random_instruction());
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      $display("Sent %0d instructions, checked %0d result transfers under three idle patterns.",
               sent_count, result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
